### hw/rtl/dlt_pkg.sv
// ----------------------------------------------------------------------------
// dlt_pkg: shared types and codes of the device liveness tracker
// Opcodes, result and status codes, the table entry record and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dlt_pkg;

	localparam int DEVICES_DEF = 32;

	// Opcodes
	localparam logic [3:0] OP_ADD       = 4'd0;
	localparam logic [3:0] OP_REMOVE    = 4'd1;
	localparam logic [3:0] OP_SEEN      = 4'd2;
	localparam logic [3:0] OP_SET_TO    = 4'd3;
	localparam logic [3:0] OP_SET_POWER = 4'd4;
	localparam logic [3:0] OP_PING_RSP  = 4'd5;
	localparam logic [3:0] OP_SEND_FAIL = 4'd6;
	localparam logic [3:0] OP_TICK      = 4'd7;
	localparam logic [3:0] OP_QUERY     = 4'd8;

	// Result kinds
	localparam logic [1:0] RK_DONE = 2'd0;
	localparam logic [1:0] RK_CHG  = 2'd1;
	localparam logic [1:0] RK_PING = 2'd2;

	// Availability
	localparam logic [1:0] AV_UNKNOWN = 2'd0;
	localparam logic [1:0] AV_ONLINE  = 2'd1;
	localparam logic [1:0] AV_OFFLINE = 2'd2;

	// Power kinds
	localparam logic [1:0] PW_UNKNOWN = 2'd0;
	localparam logic [1:0] PW_MAINS   = 2'd1;
	localparam logic [1:0] PW_INVALID = 2'd3;

	// Status codes
	localparam logic [2:0] SC_OK        = 3'd0;
	localparam logic [2:0] SC_INVALID   = 3'd1;
	localparam logic [2:0] SC_NOT_FOUND = 3'd2;
	localparam logic [2:0] SC_FULL      = 3'd3;

	// Register indexes
	localparam logic [3:0] CFG_ROUTER_INTERVAL = 4'd0;
	localparam logic [3:0] CFG_BATTERY_TIMEOUT = 4'd1;
	localparam logic [3:0] CFG_ROUTER_TIMEOUT  = 4'd2;
	localparam logic [3:0] CFG_ACTIVE_ENABLE   = 4'd3;
	localparam logic [3:0] CFG_FAILURE_LIMIT   = 4'd4;
	localparam logic [3:0] CFG_BACKOFF_CAP     = 4'd5;
	localparam logic [3:0] CFG_BACKOFF_FACTOR  = 4'd6;
	localparam logic [3:0] CFG_PING_WAIT       = 4'd7;

	localparam logic [15:0] ADDR_NONE  = 16'h0000;
	localparam logic [15:0] ADDR_BCAST = 16'hFFFF;

	typedef struct packed {
		logic [15:0] addr;
		logic [1:0]  avail;
		logic [1:0]  power;
		logic [31:0] seen_at;
		logic [31:0] last_ping;
		logic [7:0]  fail;
		logic [15:0] backoff;
		logic [31:0] custom;
		logic        pending;
		logic [31:0] due_at;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		PH_OP,
		PH_T1,
		PH_T2
	} phase_t;

	typedef struct packed {
		logic   capture;
		logic   time_inc;
		logic   idx_clr;
		logic   idx_inc;
		logic   lk_rd;
		logic   lk_cmp;
		logic   decide;
		logic   rd;
		logic   load;
		logic   eval;
		logic   mult;
		logic   plan;
		logic   write;
		logic   emit_done;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic last_idx;
		logic go;
		logic want_emit;
		logic out_busy;
		logic active;
	} sts_t;

endpackage

### hw/rtl/dlt_ram.sv
// ----------------------------------------------------------------------------
// dlt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/dlt_ctrl.sv
// ----------------------------------------------------------------------------
// dlt_ctrl: sequencer of the liveness tracker
// Steps lookup scans, entry updates and the two tick passes.
// ----------------------------------------------------------------------------
module dlt_ctrl
	import dlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE, S_CAP, S_TICK, S_LRD, S_LCMP, S_DEC,
		S_RD, S_LD, S_EV, S_PL, S_NX, S_WR, S_DONE
	} state_t;

	state_t state_q;
	phase_t phase_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.phase = phase_q;
		unique case (state_q)
			S_IDLE: cmd.capture = in_valid;
			S_CAP:  cmd.idx_clr = 1'b1;
			S_TICK: cmd.time_inc = 1'b1;
			S_LRD:  cmd.lk_rd = 1'b1;
			S_LCMP: begin
				cmd.lk_cmp = 1'b1;
				cmd.idx_inc = !sts.last_idx;
			end
			S_DEC:  cmd.decide = 1'b1;
			S_RD:   cmd.rd = 1'b1;
			S_LD:   cmd.load = 1'b1;
			S_EV:   cmd.eval = 1'b1;
			S_PL:   cmd.mult = 1'b1;
			S_NX:   cmd.plan = 1'b1;
			S_WR: begin
				cmd.write = !(sts.want_emit && sts.out_busy);
				cmd.idx_inc = cmd.write && (phase_q != PH_OP) && !sts.last_idx;
				cmd.idx_clr = cmd.write && (phase_q == PH_T1) && sts.last_idx;
			end
			S_DONE: cmd.emit_done = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_OP;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					phase_q <= sts.is_tick ? PH_T1 : PH_OP;
					state_q <= sts.is_tick ? S_TICK : S_LRD;
				end
				S_TICK: state_q <= S_RD;
				S_LRD:  state_q <= S_LCMP;
				S_LCMP: state_q <= sts.last_idx ? S_DEC : S_LRD;
				S_DEC:  state_q <= sts.go ? S_RD : S_DONE;
				S_RD:   state_q <= S_LD;
				S_LD:   state_q <= S_EV;
				S_EV:   state_q <= S_PL;
				S_PL:   state_q <= S_NX;
				S_NX:   state_q <= S_WR;
				S_WR: if (!(sts.want_emit && sts.out_busy)) begin
					if (phase_q == PH_OP) begin
						state_q <= S_DONE;
					end else if (!sts.last_idx) begin
						state_q <= S_RD;
					end else if (phase_q == PH_T1 && sts.active) begin
						phase_q <= PH_T2;
						state_q <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: if (!sts.out_busy) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/dlt_dpath.sv
// ----------------------------------------------------------------------------
// dlt_dpath: table datapath of the liveness tracker
// Holds configuration, time, the device table and the result register.
// ----------------------------------------------------------------------------
module dlt_dpath
	import dlt_pkg::*;
#(
	parameter int DEVICES = DEVICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [3:0]  in_opcode,
	input  logic [15:0] in_addr,
	input  logic [1:0]  in_power,
	input  logic [31:0] in_timeout,
	input  logic [7:0]  in_status,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_idx,
	input  logic [19:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [15:0] out_addr,
	output logic [1:0]  out_old,
	output logic [1:0]  out_new,
	output logic [2:0]  out_status,
	output logic        out_last
);

	localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int CNT_W = $clog2(DEVICES + 1);

	logic [19:0] router_interval_q, battery_timeout_q, router_timeout_q;
	logic        active_q;
	logic [7:0]  failure_limit_q, backoff_cap_q, ping_wait_q;
	logic [2:0]  backoff_factor_q;

	logic [31:0] time_q;
	logic [3:0]  op_q;
	logic [15:0] addr_q;
	logic [1:0]  pk_q;
	logic [31:0] tv_q;
	logic [7:0]  rs_q;

	logic [IDX_W-1:0] idx_q, match_idx_q, empty_idx_q;
	logic             match_q, empty_q, create_q;
	logic [2:0]       status_q;
	logic [1:0]       done_state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEVICES-1:0] valid_q, chg_q;
	logic             rvalid_q;

	entry_t      ent_q, ent_n, rent;
	logic [ENTRY_W-1:0] rdata;
	logic        plan_q, plan_n;
	logic [35:0] prod_q;
	logic        emit_en_q, emit_n;
	logic [1:0]  emit_kind_q, emit_kind_n, emit_old_q, emit_old_n, emit_new_q, emit_new_n;

	logic        out_busy, last_idx;
	logic        go, addr_bad;
	logic [2:0]  dec_status;
	logic [IDX_W-1:0] dec_idx;
	logic        dec_create;

	dlt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEVICES)) u_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (idx_q),
		.wdata (ent_q),
		.re    (cmd.lk_rd | cmd.rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Never-written slots read as empty
	assign rent = rvalid_q ? entry_t'(rdata) : '0;
	assign last_idx = (idx_q == IDX_W'(DEVICES - 1));
	assign out_busy = out_valid && !out_ready;

	assign sts.is_tick   = (op_q == OP_TICK);
	assign sts.last_idx  = last_idx;
	assign sts.go        = go;
	assign sts.want_emit = emit_en_q;
	assign sts.out_busy  = out_busy;
	assign sts.active    = active_q;

	// Lookup outcome
	always_comb begin
		addr_bad   = (addr_q == ADDR_NONE) || (addr_q == ADDR_BCAST);
		go         = 1'b0;
		dec_status = SC_OK;
		dec_idx    = match_idx_q;
		dec_create = 1'b0;
		if (op_q == OP_ADD) begin
			if (addr_bad) begin
				dec_status = SC_INVALID;
			end else if (match_q) begin
				go = 1'b1;
			end else if (cnt_q >= CNT_W'(DEVICES) || !empty_q) begin
				dec_status = SC_FULL;
			end else begin
				go         = 1'b1;
				dec_idx    = empty_idx_q;
				dec_create = 1'b1;
			end
		end else if (match_q) begin
			go = 1'b1;
		end else begin
			case (op_q) inside
				OP_REMOVE, OP_SEEN, OP_SET_TO, OP_SET_POWER,
				OP_PING_RSP, OP_SEND_FAIL, OP_QUERY: dec_status = SC_NOT_FOUND;
				default: dec_status = SC_OK;
			endcase
		end
	end

	// Entry update
	always_comb begin
		logic        do_alive, do_fail, do_set;
		logic [1:0]  tgt;
		logic [31:0] lim;
		ent_n       = ent_q;
		plan_n      = 1'b0;
		emit_n      = 1'b0;
		emit_kind_n = RK_CHG;
		emit_old_n  = AV_UNKNOWN;
		emit_new_n  = AV_UNKNOWN;
		do_alive    = 1'b0;
		do_fail     = 1'b0;
		do_set      = 1'b0;
		tgt         = AV_ONLINE;
		lim         = 32'd0;
		case (cmd.phase)
			PH_OP: begin
				case (op_q)
					OP_ADD: begin
						if (create_q) begin
							ent_n         = '0;
							ent_n.addr    = addr_q;
							ent_n.backoff = 16'd1;
							plan_n        = 1'b1;
							do_set        = 1'b1;
						end
						ent_n.power   = pk_q;
						ent_n.seen_at = time_q;
					end
					OP_REMOVE:    ent_n = '0;
					OP_SEEN:      do_alive = 1'b1;
					OP_SET_TO: begin
						ent_n.custom = tv_q;
						plan_n       = 1'b1;
					end
					OP_SET_POWER: begin
						ent_n.power = pk_q;
						plan_n      = 1'b1;
					end
					OP_PING_RSP: begin
						do_alive = (rs_q == 8'd0);
						do_fail  = (rs_q != 8'd0);
					end
					OP_SEND_FAIL: ent_n.pending = 1'b0;
					default: ent_n = ent_q;
				endcase
			end
			PH_T1: begin
				if (ent_q.custom != 32'd0) begin
					lim = ent_q.custom;
				end else if (ent_q.power == PW_MAINS) begin
					lim = {12'd0, router_timeout_q};
				end else begin
					lim = {12'd0, battery_timeout_q};
				end
				if (ent_q.addr != ADDR_NONE) begin
					if (ent_q.pending && (time_q - ent_q.last_ping) > {24'd0, ping_wait_q}) begin
						do_fail = 1'b1;
					end else if (ent_q.avail == AV_ONLINE && (time_q - ent_q.seen_at) > lim
						&& ent_q.power != PW_MAINS) begin
						do_set = 1'b1;
						tgt    = AV_OFFLINE;
					end
				end
			end
			PH_T2: begin
				if (ent_q.addr != ADDR_NONE && ent_q.power == PW_MAINS && !ent_q.pending
					&& !chg_q[idx_q] && time_q >= ent_q.due_at) begin
					ent_n.pending   = 1'b1;
					ent_n.last_ping = time_q;
					emit_n          = 1'b1;
					emit_kind_n     = RK_PING;
				end
			end
			default: ent_n = ent_q;
		endcase
		if (do_alive) begin
			ent_n.seen_at = time_q;
			ent_n.fail    = 8'd0;
			ent_n.backoff = 16'd1;
			ent_n.pending = 1'b0;
			plan_n        = 1'b1;
			do_set        = 1'b1;
			tgt           = AV_ONLINE;
		end
		if (do_fail) begin
			ent_n.pending = 1'b0;
			if (ent_n.fail != 8'hFF) begin
				ent_n.fail = ent_n.fail + 8'd1;
			end
			if (ent_n.backoff < {8'd0, backoff_cap_q}) begin
				ent_n.backoff = 16'(ent_n.backoff * backoff_factor_q);
			end
			plan_n = 1'b1;
			do_set = (ent_n.fail >= failure_limit_q);
			tgt    = AV_OFFLINE;
		end
		if (do_set && ent_n.avail != tgt) begin
			emit_n      = 1'b1;
			emit_kind_n = RK_CHG;
			emit_old_n  = ent_n.avail;
			emit_new_n  = tgt;
			ent_n.avail = tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_interval_q <= 20'd300;
			battery_timeout_q <= 20'd90000;
			router_timeout_q  <= 20'd600;
			active_q          <= 1'b1;
			failure_limit_q   <= 8'd3;
			backoff_cap_q     <= 8'd8;
			backoff_factor_q  <= 3'd2;
			ping_wait_q       <= 8'd10;
			time_q            <= 32'd0;
			cnt_q             <= '0;
			valid_q           <= '0;
			chg_q             <= '0;
			out_valid         <= 1'b0;
			emit_en_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ROUTER_INTERVAL: router_interval_q <= cfg_wdata;
					CFG_BATTERY_TIMEOUT: battery_timeout_q <= cfg_wdata;
					CFG_ROUTER_TIMEOUT:  router_timeout_q  <= cfg_wdata;
					CFG_ACTIVE_ENABLE:   active_q          <= cfg_wdata[0];
					CFG_FAILURE_LIMIT:   failure_limit_q   <= cfg_wdata[7:0];
					CFG_BACKOFF_CAP:     backoff_cap_q     <= cfg_wdata[7:0];
					CFG_BACKOFF_FACTOR:  backoff_factor_q  <= cfg_wdata[2:0];
					CFG_PING_WAIT:       ping_wait_q       <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (cmd.time_inc) begin
				time_q <= time_q + 32'd1;
			end
			if (cmd.eval) begin
				emit_en_q <= emit_n;
			end
			if (cmd.write) begin
				valid_q[idx_q] <= 1'b1;
				if (cmd.phase == PH_T1) begin
					chg_q[idx_q] <= emit_en_q;
				end
				if (cmd.phase == PH_OP) begin
					if (op_q == OP_ADD && create_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (op_q == OP_REMOVE && cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
			end
			// A new load wins; otherwise drop the request once taken
			if ((cmd.write && emit_en_q) || cmd.emit_done) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= in_opcode;
			addr_q       <= in_addr;
			pk_q         <= (in_power == PW_INVALID) ? PW_UNKNOWN : in_power;
			tv_q         <= in_timeout;
			rs_q         <= in_status;
			match_q      <= 1'b0;
			empty_q      <= 1'b0;
			create_q     <= 1'b0;
			status_q     <= SC_OK;
			done_state_q <= AV_UNKNOWN;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end else if (cmd.decide) begin
			idx_q <= dec_idx;
		end
		if (cmd.lk_rd | cmd.rd) begin
			rvalid_q <= valid_q[idx_q];
		end
		if (cmd.lk_cmp) begin
			if (!match_q && addr_q != ADDR_NONE && rent.addr == addr_q) begin
				match_q     <= 1'b1;
				match_idx_q <= idx_q;
			end
			if (!empty_q && rent.addr == ADDR_NONE) begin
				empty_q     <= 1'b1;
				empty_idx_q <= idx_q;
			end
		end
		if (cmd.decide) begin
			status_q <= dec_status;
			create_q <= dec_create;
		end
		if (cmd.load) begin
			ent_q <= rent;
		end
		if (cmd.eval) begin
			ent_q       <= ent_n;
			plan_q      <= plan_n;
			emit_kind_q <= emit_kind_n;
			emit_old_q  <= emit_old_n;
			emit_new_q  <= emit_new_n;
		end
		if (cmd.mult) begin
			prod_q <= router_interval_q * ent_q.backoff;
		end
		if (cmd.plan && plan_q) begin
			ent_q.due_at <= time_q + ((ent_q.power == PW_MAINS) ? prod_q[31:0]
				: {12'd0, battery_timeout_q});
		end
		if (cmd.write && cmd.phase == PH_OP) begin
			done_state_q <= ent_q.avail;
		end
		if (cmd.write && emit_en_q) begin
			out_kind   <= emit_kind_q;
			out_addr   <= ent_q.addr;
			out_old    <= emit_old_q;
			out_new    <= emit_new_q;
			out_status <= SC_OK;
			out_last   <= 1'b0;
		end else if (cmd.emit_done) begin
			out_kind   <= RK_DONE;
			out_addr   <= (op_q == OP_TICK) ? ADDR_NONE : addr_q;
			out_old    <= AV_UNKNOWN;
			out_new    <= done_state_q;
			out_status <= status_q;
			out_last   <= 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEVICES))
		else $error("tracked count above table size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.write && emit_en_q) || cmd.emit_done) |-> !out_busy)
		else $error("result loaded over a waiting request");

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> (out_kind == RK_DONE))
		else $error("final result is not a completion");

endmodule

### hw/rtl/device_liveness_tracker.sv
// ----------------------------------------------------------------------------
// device_liveness_tracker: table of network devices and their liveness
// Tracks up to DEVICES devices, times out silent ones and schedules pings.
// ----------------------------------------------------------------------------
// Each request runs to the end before the next is taken. A device operation
// scans the table once to find the address, reading and comparing each
// slot in turn, then reads, updates and writes back the entry and delivers
// its results. A tick walks the table once for timeouts and, when
// scheduled pings are enabled, once more for due mains devices; each slot
// in each pass goes through entry read, load, update, backoff multiply,
// next-check add and write-back. A stalled output holds the write-back and
// the completion. The table is empty right after reset with no clearing
// pass: slot valid bits are cleared at once. Configuration writes are taken
// at any time but are meant for an idle block.
// ----------------------------------------------------------------------------
module device_liveness_tracker
	import dlt_pkg::*;
#(
	parameter int DEVICES = DEVICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] device_addr, [17:16] power_kind, [49:18] timeout_value,
	// [57:50] response_status, rest zero
	input  logic [63:0] s_axis_tdata,
	// [3:0] opcode
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] device_addr_out, [17:16] previous availability,
	// [19:18] resulting availability, [22:20] status_code, [23] zero
	output logic [23:0] m_axis_tdata,
	// [1:0] result_kind
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic [1:0] out_old, out_new;
	logic [2:0] out_status;
	logic [15:0] out_addr;

	// Always take register writes
	assign cfg_ready = 1'b1;

	dlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dlt_dpath #(.DEVICES(DEVICES)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_opcode  (s_axis_tuser),
		.in_addr    (s_axis_tdata[15:0]),
		.in_power   (s_axis_tdata[17:16]),
		.in_timeout (s_axis_tdata[49:18]),
		.in_status  (s_axis_tdata[57:50]),
		.cfg_we     (cfg_valid),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (m_axis_tuser),
		.out_addr   (out_addr),
		.out_old    (out_old),
		.out_new    (out_new),
		.out_status (out_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_status, out_new, out_old, out_addr};

endmodule

### tb/device_liveness_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_liveness_tracker_tb: self-checking bench of the liveness tracker
// Drives requests on the input stream and configuration writes while idle,
// predicts every result with a behavioral copy of the tracker table, and
// checks each result in order, field by field, under random gaps and stalls.
// ----------------------------------------------------------------------------
module device_liveness_tracker_tb;
	import dlt_pkg::*;

	localparam int NDEV       = 32;
	localparam int WDOG_LIMIT = 8000;  // cycles with no handshake anywhere
	localparam int HOLD_LONG  = 500;   // long output hold-off, fills the block

	// ------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	device_liveness_tracker dut (.*);

	// ------------------------------------------------------------------
	// Tracker model: configuration, table and expected results
	// ------------------------------------------------------------------
	typedef struct {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [1:0]  old_st;
		logic [1:0]  new_st;
		logic [2:0]  status;
		logic        last;
	} result_t;

	result_t     pending_results[$];

	logic [19:0] r_interval, bat_to, rtr_to;
	logic        act_en;
	logic [7:0]  fail_lim, bo_cap, p_wait;
	logic [2:0]  bo_fac;

	logic [31:0] now;
	logic [15:0] t_addr[NDEV];
	logic [1:0]  t_avail[NDEV];
	logic [1:0]  t_power[NDEV];
	logic [31:0] t_seen[NDEV];
	logic [31:0] t_pinged[NDEV];
	logic [7:0]  t_fails[NDEV];
	logic [15:0] t_backoff[NDEV];
	logic [31:0] t_custom[NDEV];
	logic        t_pend[NDEV];
	logic [31:0] t_next[NDEV];
	int          t_count;
	logic [2:0]  done_status;   // status of the last predicted completion

	function automatic void push_result(logic [1:0] k, logic [15:0] a, logic [1:0] o,
			logic [1:0] n, logic [2:0] s, logic l);
		result_t r;
		r.kind = k; r.addr = a; r.old_st = o; r.new_st = n; r.status = s; r.last = l;
		pending_results.push_back(r);
	endfunction

	function automatic void schedule_check(int i);
		logic [31:0] iv;
		if (t_power[i] == PW_MAINS)
			iv = 32'(r_interval) * 32'(t_backoff[i]);
		else
			iv = 32'(bat_to);
		t_next[i] = now + iv;
	endfunction

	function automatic bit move_avail(int i, logic [1:0] st);
		if (t_avail[i] == st)
			return 1'b0;
		push_result(RK_CHG, t_addr[i], t_avail[i], st, SC_OK, 1'b0);
		t_avail[i] = st;
		return 1'b1;
	endfunction

	function automatic bit count_failure(int i);
		t_pend[i] = 1'b0;
		if (t_fails[i] < 8'd255)
			t_fails[i]++;
		if (t_backoff[i] < 16'(bo_cap))
			t_backoff[i] = 16'(32'(t_backoff[i]) * 32'(bo_fac));
		schedule_check(i);
		if (t_fails[i] >= fail_lim)
			return move_avail(i, AV_OFFLINE);
		return 1'b0;
	endfunction

	function automatic void revive(int i);
		bit ch;
		t_seen[i] = now;
		t_fails[i] = '0;
		t_backoff[i] = 16'd1;
		t_pend[i] = 1'b0;
		schedule_check(i);
		ch = move_avail(i, AV_ONLINE);
	endfunction

	function automatic void advance_second();
		bit          hit[NDEV];
		logic [31:0] lim;
		now++;
		// timeout pass: overdue pings first, then silent non-mains devices
		for (int i = 0; i < NDEV; i++) begin
			hit[i] = 1'b0;
			if (t_addr[i] == ADDR_NONE)
				continue;
			if (t_custom[i] != 0)
				lim = t_custom[i];
			else
				lim = (t_power[i] == PW_MAINS) ? 32'(rtr_to) : 32'(bat_to);
			if (t_pend[i] && (now - t_pinged[i]) > 32'(p_wait))
				hit[i] = count_failure(i);
			else if (t_avail[i] == AV_ONLINE && (now - t_seen[i]) > lim &&
					t_power[i] != PW_MAINS)
				hit[i] = move_avail(i, AV_OFFLINE);
		end
		if (!act_en)
			return;
		// ping pass: due mains devices that did not change state this tick
		for (int i = 0; i < NDEV; i++) begin
			if (t_addr[i] == ADDR_NONE || t_power[i] != PW_MAINS || t_pend[i] || hit[i])
				continue;
			if (now >= t_next[i]) begin
				t_pend[i] = 1'b1;
				t_pinged[i] = now;
				push_result(RK_PING, t_addr[i], AV_UNKNOWN, AV_UNKNOWN, SC_OK, 1'b0);
			end
		end
	endfunction

	function automatic void predict_request(logic [3:0] op, logic [15:0] a, logic [1:0] pk_in,
			logic [31:0] tv, logic [7:0] rs);
		int         i, k;
		logic [1:0] pk;
		logic [2:0] st;
		bit         ch;
		st = SC_OK;
		pk = (pk_in == PW_INVALID) ? PW_UNKNOWN : pk_in;
		if (op == OP_TICK) begin
			advance_second();
			push_result(RK_DONE, 16'h0, AV_UNKNOWN, AV_UNKNOWN, SC_OK, 1'b1);
			done_status = SC_OK;
			return;
		end
		i = -1;
		if (a != ADDR_NONE)
			for (int j = 0; j < NDEV; j++)
				if (t_addr[j] == a && i < 0)
					i = j;
		case (op)
			OP_ADD: begin
				if (a == ADDR_NONE || a == ADDR_BCAST) begin
					st = SC_INVALID;
				end else if (i >= 0) begin
					t_power[i] = pk;
					t_seen[i] = now;
				end else if (t_count >= NDEV) begin
					st = SC_FULL;
				end else begin
					for (k = 0; k < NDEV && t_addr[k] != ADDR_NONE; k++) ;
					if (k >= NDEV) begin
						st = SC_FULL;
					end else begin
						i = k;
						t_addr[i] = a; t_avail[i] = AV_UNKNOWN; t_power[i] = pk;
						t_seen[i] = now; t_pinged[i] = '0; t_fails[i] = '0;
						t_backoff[i] = 16'd1; t_custom[i] = '0; t_pend[i] = 1'b0;
						schedule_check(i);
						t_count++;
						ch = move_avail(i, AV_ONLINE);
					end
				end
			end
			OP_REMOVE: begin
				if (i < 0) begin
					st = SC_NOT_FOUND;
				end else begin
					t_addr[i] = '0; t_avail[i] = '0; t_power[i] = '0; t_seen[i] = '0;
					t_pinged[i] = '0; t_fails[i] = '0; t_backoff[i] = '0;
					t_custom[i] = '0; t_pend[i] = 1'b0; t_next[i] = '0;
					if (t_count > 0)
						t_count--;
					i = -1;
				end
			end
			OP_SEEN: begin
				if (i < 0) st = SC_NOT_FOUND;
				else revive(i);
			end
			OP_SET_TO: begin
				if (i < 0) st = SC_NOT_FOUND;
				else begin t_custom[i] = tv; schedule_check(i); end
			end
			OP_SET_POWER: begin
				if (i < 0) st = SC_NOT_FOUND;
				else begin t_power[i] = pk; schedule_check(i); end
			end
			OP_PING_RSP: begin
				if (i < 0) st = SC_NOT_FOUND;
				else if (rs == 8'd0) revive(i);
				else ch = count_failure(i);
			end
			OP_SEND_FAIL: begin
				if (i < 0) st = SC_NOT_FOUND;
				else t_pend[i] = 1'b0;
			end
			OP_QUERY: begin
				if (i < 0) st = SC_NOT_FOUND;
			end
			default: ;
		endcase
		push_result(RK_DONE, a, AV_UNKNOWN, (i >= 0) ? t_avail[i] : AV_UNKNOWN, st, 1'b1);
		done_status = st;
	endfunction

	function automatic void apply_reg(logic [3:0] idx, logic [19:0] d);
		case (idx)
			CFG_ROUTER_INTERVAL: r_interval = d;
			CFG_BATTERY_TIMEOUT: bat_to = d;
			CFG_ROUTER_TIMEOUT:  rtr_to = d;
			CFG_ACTIVE_ENABLE:   act_en = d[0];
			CFG_FAILURE_LIMIT:   fail_lim = d[7:0];
			CFG_BACKOFF_CAP:     bo_cap = d[7:0];
			CFG_BACKOFF_FACTOR:  bo_fac = d[2:0];
			CFG_PING_WAIT:       p_wait = d[7:0];
			default: ;
		endcase
	endfunction

	initial begin
		r_interval = 20'd300; bat_to = 20'd90000; rtr_to = 20'd600; act_en = 1'b1;
		fail_lim = 8'd3; bo_cap = 8'd8; bo_fac = 3'd2; p_wait = 8'd10;
		now = '0; t_count = 0; done_status = SC_OK;
		for (int i = 0; i < NDEV; i++) begin
			t_addr[i] = '0; t_avail[i] = '0; t_power[i] = '0; t_seen[i] = '0;
			t_pinged[i] = '0; t_fails[i] = '0; t_backoff[i] = '0; t_custom[i] = '0;
			t_pend[i] = 1'b0; t_next[i] = '0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on accepted requests, check accepted results
	// ------------------------------------------------------------------
	int       errors = 0;
	int       n_requests = 0, n_results = 0, n_changes = 0, n_pings = 0, n_cfg = 0;
	int       idle_cycles = 0;
	logic     pin_done = 1'b0;      // directed row carries a typed-in status
	logic [2:0] pin_status = SC_OK;

	always @(posedge clk) begin
		result_t exp_r;
		result_t got;
		bit      moved;
		moved = 1'b0;
		if (cfg_valid && cfg_ready) begin
			apply_reg(cfg_index, cfg_data);
			n_cfg++;
			moved = 1'b1;
		end
		if (s_axis_tvalid && s_axis_tready) begin
			predict_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[17:16],
				s_axis_tdata[49:18], s_axis_tdata[57:50]);
			n_requests++;
			moved = 1'b1;
			if (pin_done && done_status != pin_status) begin
				$display("%0t: op %0d addr %h status expected %0d, model gives %0d", $time,
					s_axis_tuser, s_axis_tdata[15:0], pin_status, done_status);
				errors++;
			end
		end
		if (m_axis_tvalid && m_axis_tready) begin
			moved = 1'b1;
			n_results++;
			got.kind = m_axis_tuser; got.addr = m_axis_tdata[15:0];
			got.old_st = m_axis_tdata[17:16]; got.new_st = m_axis_tdata[19:18];
			got.status = m_axis_tdata[22:20]; got.last = m_axis_tlast;
			if (got.kind == RK_CHG) n_changes++;
			if (got.kind == RK_PING) n_pings++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d addr %h", $time, got.kind, got.addr);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.kind != exp_r.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
					errors++;
				end
				if (got.addr != exp_r.addr) begin
					$display("%0t: addr expected %h actual %h", $time, exp_r.addr, got.addr);
					errors++;
				end
				if (got.old_st != exp_r.old_st) begin
					$display("%0t: prev_avail expected %0d actual %0d", $time, exp_r.old_st,
						got.old_st);
					errors++;
				end
				if (got.new_st != exp_r.new_st) begin
					$display("%0t: cur_avail expected %0d actual %0d", $time, exp_r.new_st,
						got.new_st);
					errors++;
				end
				if (got.status != exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
						got.status);
					errors++;
				end
				if (got.last != exp_r.last) begin
					$display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
					errors++;
				end
			end
		end
		// watchdog: any handshake resets the count
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold-off on request
	// ------------------------------------------------------------------
	logic hold_req = 1'b0;

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_LONG;
			end else begin
				// stretches of full throughput in between
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			end
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	logic burst_mode = 1'b0;   // no gaps while set

	task automatic send_request(logic [3:0] op, logic [15:0] a, logic [1:0] pk,
			logic [31:0] tv, logic [7:0] rs, logic pin = 1'b0, logic [2:0] pst = SC_OK);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser = op;
		s_axis_tdata = {6'd0, rs, tv, pk, a};
		pin_done = pin;
		pin_status = pst;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [19:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain every expected result, then let the block settle
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		pin_done = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic load_config(logic [19:0] ri, logic [19:0] bt, logic [19:0] rt, logic ae,
			logic [7:0] fl, logic [7:0] bc, logic [2:0] bf, logic [7:0] pw);
		wait_idle();
		write_reg(CFG_ROUTER_INTERVAL, ri);
		write_reg(CFG_BATTERY_TIMEOUT, bt);
		write_reg(CFG_ROUTER_TIMEOUT, rt);
		write_reg(CFG_ACTIVE_ENABLE, 20'(ae));
		write_reg(CFG_FAILURE_LIMIT, 20'(fl));
		write_reg(CFG_BACKOFF_CAP, 20'(bc));
		write_reg(CFG_BACKOFF_FACTOR, 20'(bf));
		write_reg(CFG_PING_WAIT, 20'(pw));
	endtask

	// Directed rows; pin marks rows whose completion status is typed in
	typedef struct {
		logic [3:0]  op;
		logic [15:0] a;
		logic [1:0]  pk;
		logic [31:0] tv;
		logic [7:0]  rs;
		logic        pin;
		logic [2:0]  st;
	} row_t;

	localparam int NROWS = 25;
	row_t rows[NROWS] = '{
		'{OP_QUERY,     16'h0001, 2'd0, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND},
		'{OP_ADD,       16'h0000, 2'd1, 32'h0,        8'h00, 1'b1, SC_INVALID},
		'{OP_ADD,       16'hFFFF, 2'd1, 32'h0,        8'h00, 1'b1, SC_INVALID},
		'{OP_REMOVE,    16'h0000, 2'd0, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND},
		'{OP_SEEN,      16'h0000, 2'd0, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND},
		'{OP_ADD,       16'h1234, 2'd1, 32'h0,        8'h00, 1'b1, SC_OK},
		'{OP_ADD,       16'h0BAD, 2'd3, 32'h0,        8'h00, 1'b1, SC_OK},
		'{OP_ADD,       16'h8001, 2'd2, 32'h0,        8'h00, 1'b1, SC_OK},
		'{OP_ADD,       16'h1234, 2'd0, 32'h0,        8'h00, 1'b0, SC_OK},
		'{OP_SET_POWER, 16'h1234, 2'd1, 32'h0,        8'h00, 1'b0, SC_OK},
		'{OP_SET_TO,    16'h0BAD, 2'd0, 32'hFFFFFFFF, 8'h00, 1'b0, SC_OK},
		'{OP_SET_TO,    16'h0BAD, 2'd0, 32'h0,        8'h00, 1'b0, SC_OK},
		'{OP_SEEN,      16'h8001, 2'd0, 32'h0,        8'h00, 1'b0, SC_OK},
		'{OP_PING_RSP,  16'h1234, 2'd0, 32'h0,        8'hFF, 1'b0, SC_OK},
		'{OP_PING_RSP,  16'h1234, 2'd0, 32'h0,        8'h00, 1'b0, SC_OK},
		'{OP_SEND_FAIL, 16'h1234, 2'd0, 32'h0,        8'h00, 1'b0, SC_OK},
		'{OP_TICK,      16'hFFFF, 2'd3, 32'hFFFFFFFF, 8'hFF, 1'b1, SC_OK},
		'{4'd9,         16'h1234, 2'd0, 32'h0,        8'h00, 1'b1, SC_OK},
		'{4'd15,        16'hFFFF, 2'd3, 32'hFFFFFFFF, 8'hFF, 1'b1, SC_OK},
		'{OP_QUERY,     16'h1234, 2'd0, 32'h0,        8'h00, 1'b1, SC_OK},
		'{OP_REMOVE,    16'h8001, 2'd0, 32'h0,        8'h00, 1'b1, SC_OK},
		'{OP_REMOVE,    16'h8001, 2'd0, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND},
		'{OP_PING_RSP,  16'h7777, 2'd0, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND},
		'{OP_SEND_FAIL, 16'h7777, 2'd0, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND},
		'{OP_SET_POWER, 16'h7777, 2'd1, 32'h0,        8'h00, 1'b1, SC_NOT_FOUND}
	};

	logic [15:0] addr_pool[10];

	// one random request, mostly well formed against the address pool
	task automatic random_request();
		int          pick;
		logic [15:0] a;
		logic [31:0] tv;
		logic [7:0]  rs;
		logic [3:0]  op;
		pick = $urandom_range(0, 99);
		a = addr_pool[$urandom_range(0, 9)];
		tv = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 12));
		rs = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		if (pick < 28) op = OP_TICK;
		else if (pick < 42) op = OP_ADD;
		else if (pick < 54) op = OP_SEEN;
		else if (pick < 68) op = OP_PING_RSP;
		else if (pick < 73) op = OP_SEND_FAIL;
		else if (pick < 78) op = OP_SET_TO;
		else if (pick < 85) op = OP_SET_POWER;
		else if (pick < 90) op = OP_REMOVE;
		else if (pick < 96) op = OP_QUERY;
		else begin
			// noise: any opcode, any address
			op = 4'($urandom_range(0, 15));
			a = 16'($urandom());
		end
		send_request(op, a, 2'($urandom_range(0, 3)), tv, rs);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed part, reset configuration
		for (int r = 0; r < NROWS; r++)
			send_request(rows[r].op, rows[r].a, rows[r].pk, rows[r].tv, rows[r].rs,
				rows[r].pin, rows[r].st);

		for (int i = 0; i < 10; i++)
			addr_pool[i] = 16'($urandom_range(1, 16'hFFFE));

		// random phases: mostly short timers so timeouts and pings happen often
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: load_config(20'd1, 20'd1, 20'd1, 1'b1, 8'd1, 8'd1, 3'd1, 8'd1);
				1: load_config(20'd1000000, 20'd1000000, 20'd1000000, 1'b1, 8'd255,
					8'd128, 3'd4, 8'd255);
				default: load_config(20'($urandom_range(1, 4)), 20'($urandom_range(2, 9)),
					20'($urandom_range(2, 6)), 1'($urandom_range(0, 3) != 0),
					8'($urandom_range(1, 4)), 8'($urandom_range(1, 128)),
					3'($urandom_range(1, 4)), 8'($urandom_range(1, 3)));
			endcase
			if (ph == 2)
				hold_req = 1'b1;
			// a burst with no gaps during the long hold-off fills the block
			burst_mode = (ph == 2);
			for (int n = 0; n < 16; n++) begin
				if (n == 12)
					burst_mode = 1'b0;
				random_request();
			end
		end

		// failure counter saturation, scheduled pings off
		load_config(20'd2, 20'd5, 20'd3, 1'b0, 8'd255, 8'd128, 3'd4, 8'd2);
		send_request(OP_ADD, 16'h00AA, 2'd1, 32'h0, 8'h00);
		for (int n = 0; n < 258; n++)
			send_request(OP_PING_RSP, 16'h00AA, 2'd0, 32'h0, 8'($urandom_range(1, 255)));
		send_request(OP_TICK, 16'h0, 2'd0, 32'h0, 8'h00);
		send_request(OP_QUERY, 16'h00AA, 2'd0, 32'h0, 8'h00);

		// fill the table past its size, then tick with every slot busy
		load_config(20'd1, 20'd3, 20'd2, 1'b1, 8'd2, 8'd8, 3'd2, 8'd1);
		for (int k = 0; k < NDEV + 2; k++)
			send_request(OP_ADD, 16'h4000 + 16'(k), 2'(k % 2 + 1), 32'h0, 8'h00);
		for (int n = 0; n < 8; n++)
			send_request(OP_TICK, 16'h0, 2'd0, 32'h0, 8'h00);
		for (int k = 0; k < NDEV + 2; k++)
			send_request(OP_REMOVE, 16'h4000 + 16'(k), 2'd0, 32'h0, 8'h00);
		for (int n = 0; n < 20; n++)
			random_request();

		wait_idle();
		repeat (100) @(negedge clk);
		$display("Run covered %0d requests and %0d register writes over 7 settings;",
			n_requests, n_cfg);
		$display("%0d results checked, %0d state changes, %0d ping requests.",
			n_results, n_changes, n_pings);
		if (errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
